// File: rtl/core/etot_pkg.sv
package etot_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FIRST_DIVISOR   = 2;

  localparam int PC_W = 5;

  localparam logic [1:0] HOLD_NONE = 2'd0;
  localparam logic [1:0] HOLD_IN   = 2'd1;
  localparam logic [1:0] HOLD_DIV  = 2'd2;
  localparam logic [1:0] HOLD_OUT  = 2'd3;

  localparam logic [3:0] ACT_NONE         = 4'd0;
  localparam logic [3:0] ACT_LOAD         = 4'd1;
  localparam logic [3:0] ACT_DIV_REST_D   = 4'd2;
  localparam logic [3:0] ACT_DIV_RES_D    = 4'd3;
  localparam logic [3:0] ACT_DIV_RES_REST = 4'd4;
  localparam logic [3:0] ACT_REST_Q       = 4'd5;
  localparam logic [3:0] ACT_RES_SUB      = 4'd6;
  localparam logic [3:0] ACT_D_INC        = 4'd7;
  localparam logic [3:0] ACT_EMIT         = 4'd8;

  localparam logic [2:0] BR_NEVER    = 3'd0;
  localparam logic [2:0] BR_ALWAYS   = 3'd1;
  localparam logic [2:0] BR_D_GT_Q   = 3'd2;
  localparam logic [2:0] BR_REM_NZ   = 3'd3;
  localparam logic [2:0] BR_REST_LE1 = 3'd4;

  localparam logic [PC_W-1:0] STEP_IDLE      = 5'd0;
  localparam logic [PC_W-1:0] STEP_DIV_TRY   = 5'd1;
  localparam logic [PC_W-1:0] STEP_WAIT_TRY  = 5'd2;
  localparam logic [PC_W-1:0] STEP_TEST_END  = 5'd3;
  localparam logic [PC_W-1:0] STEP_TEST_REM  = 5'd4;
  localparam logic [PC_W-1:0] STEP_TAKE_Q    = 5'd5;
  localparam logic [PC_W-1:0] STEP_DIV_RES   = 5'd6;
  localparam logic [PC_W-1:0] STEP_WAIT_RES  = 5'd7;
  localparam logic [PC_W-1:0] STEP_SUB_RES   = 5'd8;
  localparam logic [PC_W-1:0] STEP_DIV_AGAIN = 5'd9;
  localparam logic [PC_W-1:0] STEP_WAIT_AG   = 5'd10;
  localparam logic [PC_W-1:0] STEP_TAKE_AG   = 5'd11;
  localparam logic [PC_W-1:0] STEP_NEXT_D    = 5'd12;
  localparam logic [PC_W-1:0] STEP_TAIL      = 5'd13;
  localparam logic [PC_W-1:0] STEP_DIV_TAIL  = 5'd14;
  localparam logic [PC_W-1:0] STEP_WAIT_TAIL = 5'd15;
  localparam logic [PC_W-1:0] STEP_SUB_TAIL  = 5'd16;
  localparam logic [PC_W-1:0] STEP_EMIT      = 5'd17;

  typedef struct packed {
    logic [1:0]      hold;
    logic [3:0]      act;
    logic [2:0]      br;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
  } div_sts_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{hold: HOLD_NONE, act: ACT_NONE, br: BR_ALWAYS, target: STEP_IDLE};
    unique case (pc)
      STEP_IDLE:      w = '{HOLD_IN,   ACT_LOAD,         BR_NEVER,    STEP_IDLE};
      STEP_DIV_TRY:   w = '{HOLD_NONE, ACT_DIV_REST_D,   BR_NEVER,    STEP_IDLE};
      STEP_WAIT_TRY:  w = '{HOLD_DIV,  ACT_NONE,         BR_NEVER,    STEP_IDLE};
      STEP_TEST_END:  w = '{HOLD_NONE, ACT_NONE,         BR_D_GT_Q,   STEP_TAIL};
      STEP_TEST_REM:  w = '{HOLD_NONE, ACT_NONE,         BR_REM_NZ,   STEP_NEXT_D};
      STEP_TAKE_Q:    w = '{HOLD_NONE, ACT_REST_Q,       BR_NEVER,    STEP_IDLE};
      STEP_DIV_RES:   w = '{HOLD_NONE, ACT_DIV_RES_D,    BR_NEVER,    STEP_IDLE};
      STEP_WAIT_RES:  w = '{HOLD_DIV,  ACT_NONE,         BR_NEVER,    STEP_IDLE};
      STEP_SUB_RES:   w = '{HOLD_NONE, ACT_RES_SUB,      BR_NEVER,    STEP_IDLE};
      STEP_DIV_AGAIN: w = '{HOLD_NONE, ACT_DIV_REST_D,   BR_NEVER,    STEP_IDLE};
      STEP_WAIT_AG:   w = '{HOLD_DIV,  ACT_NONE,         BR_REM_NZ,   STEP_NEXT_D};
      STEP_TAKE_AG:   w = '{HOLD_NONE, ACT_REST_Q,       BR_ALWAYS,   STEP_DIV_AGAIN};
      STEP_NEXT_D:    w = '{HOLD_NONE, ACT_D_INC,        BR_ALWAYS,   STEP_DIV_TRY};
      STEP_TAIL:      w = '{HOLD_NONE, ACT_NONE,         BR_REST_LE1, STEP_EMIT};
      STEP_DIV_TAIL:  w = '{HOLD_NONE, ACT_DIV_RES_REST, BR_NEVER,    STEP_IDLE};
      STEP_WAIT_TAIL: w = '{HOLD_DIV,  ACT_NONE,         BR_NEVER,    STEP_IDLE};
      STEP_SUB_TAIL:  w = '{HOLD_NONE, ACT_RES_SUB,      BR_NEVER,    STEP_IDLE};
      STEP_EMIT:      w = '{HOLD_OUT,  ACT_EMIT,         BR_ALWAYS,   STEP_IDLE};
      default:        w = '{HOLD_NONE, ACT_NONE,         BR_ALWAYS,   STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/euler_totient.sv
// Euler totient: one n_value in, one totient out, computed as n * prod(1 - 1/p) over the
// distinct primes found by trial division with d = 2, 3, ... while d <= rest / d. A small
// microcode ROM steps a datapath around one shared restoring divider that delivers one
// quotient bit per cycle. Each trial divisor costs one division, plus one division for
// each time a prime is divided out and one for each distinct prime. One n is worked on
// at a time; the next is taken once the current result has moved into the output
// register. n = 0 gives 0.
module euler_totient
  import etot_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] in_n_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] out_totient
);

  logic [PC_W-1:0]        pc_r;
  logic [PC_W-1:0]        pc_nxt;
  logic [VALUE_WIDTH-1:0] rest_r;
  logic [VALUE_WIDTH-1:0] res_r;
  logic [VALUE_WIDTH-1:0] d_r;
  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] out_totient_r;

  ucode_t                 uw;
  logic                   held;
  logic                   taken;
  logic                   run;
  div_ctl_t               div_ctl;
  div_sts_t               div_sts;
  logic [VALUE_WIDTH-1:0] div_a;
  logic [VALUE_WIDTH-1:0] div_b;
  logic [VALUE_WIDTH-1:0] quo;
  logic [VALUE_WIDTH-1:0] rem;

  assign uw  = ucode_rom(pc_r);

  always_comb begin
    unique case (uw.hold)
      HOLD_IN:  held = !in_valid;
      HOLD_DIV: held = div_sts.busy;
      HOLD_OUT: held = out_valid_r && out_stall;
      default:  held = 1'b0;
    endcase
  end

  assign run = !held;

  always_comb begin
    unique case (uw.br)
      BR_ALWAYS:   taken = 1'b1;
      BR_D_GT_Q:   taken = (d_r > quo);
      BR_REM_NZ:   taken = (rem != '0);
      BR_REST_LE1: taken = (rest_r[VALUE_WIDTH-1:1] == '0);
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    if (held) begin
      pc_nxt = pc_r;
    end else if (taken) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  always_comb begin
    div_ctl.start = 1'b0;
    div_a         = rest_r;
    div_b         = d_r;
    case (uw.act)
      ACT_DIV_REST_D: begin
        div_ctl.start = run;
      end
      ACT_DIV_RES_D: begin
        div_ctl.start = run;
        div_a         = res_r;
      end
      ACT_DIV_RES_REST: begin
        div_ctl.start = run;
        div_a         = res_r;
        div_b         = rest_r;
      end
      default: begin
        div_ctl.start = 1'b0;
      end
    endcase
  end

  etot_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (div_a),
    .divisor   (div_b),
    .sts       (div_sts),
    .quotient  (quo),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (run) begin
      case (uw.act)
        ACT_LOAD: begin
          rest_r <= in_n_value;
          res_r  <= in_n_value;
          d_r    <= VALUE_WIDTH'(FIRST_DIVISOR);
        end
        ACT_REST_Q:  rest_r <= quo;
        ACT_RES_SUB: res_r  <= res_r - quo;
        ACT_D_INC:   d_r    <= d_r + VALUE_WIDTH'(1);
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (run && (uw.act == ACT_EMIT)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (run && (uw.act == ACT_EMIT)) begin
      out_totient_r <= res_r;
    end
  end

  assign in_stall    = (pc_r != STEP_IDLE);
  assign out_valid   = out_valid_r;
  assign out_totient = out_totient_r;

endmodule

// File: rtl/core/etot_div.sv
module etot_div
  import etot_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  div_ctl_t               ctl,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output div_sts_t               sts,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [VALUE_WIDTH-1:0] remainder
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [CNT_W-1:0]       cnt_r;
  logic [VALUE_WIDTH-1:0] rem_r;
  logic [VALUE_WIDTH-1:0] quo_r;
  logic [VALUE_WIDTH-1:0] den_r;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   den_ext;
  logic                   fits;

  assign trial   = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign den_ext = {1'b0, den_r};
  assign fits    = (trial >= den_ext);

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.start) begin
      cnt_r <= CNT_W'(VALUE_WIDTH);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (cnt_r != '0) begin
      if (fits) begin
        rem_r <= VALUE_WIDTH'(trial - den_ext);
        quo_r <= {quo_r[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= trial[VALUE_WIDTH-1:0];
        quo_r <= {quo_r[VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign sts.busy  = (cnt_r != '0);
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: verif/euler_totient_tb.sv
`timescale 1ns / 100ps

module euler_totient_tb;
  import etot_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;
  localparam logic [63:0] TOP_VALUE = (64'd1 << VW) - 64'd1;
  localparam int unsigned LIMIT_CYCLES = 4_000_000;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int NUM_EDGE = 22;
  localparam int EXP_DEPTH = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [VW-1:0] in_n_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [VW-1:0] out_totient;

  logic [VW-1:0] phi_pending[EXP_DEPTH];
  logic [3:0] exp_wr = '0;
  logic [3:0] exp_rd = '0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit jitter_on = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned sink_burst;

  euler_totient #(
    .VALUE_WIDTH(VW)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_n_value(in_n_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_totient(out_totient)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // phi(n) = n * prod(1 - 1/p) over distinct primes, found by trial division
  function automatic logic [VW-1:0] totient_of(input logic [VW-1:0] n);
    logic [63:0] rest;
    logic [63:0] acc;
    logic [63:0] d;
    if (n == '0) return '0;
    rest = 64'(n);
    acc = 64'(n);
    for (d = 64'd2; d <= rest / d; d++) begin
      if (rest % d == 64'd0) begin
        acc -= acc / d;
        while (rest % d == 64'd0) rest /= d;
      end
    end
    if (rest > 64'd1) acc -= acc / rest;
    return acc[VW-1:0];
  endfunction

  // product of small factors, so trial division ends early even for wide n
  function automatic logic [VW-1:0] smooth_n();
    logic [63:0] prod;
    logic [63:0] f;
    bit fill;
    prod = 64'($urandom_range(1, 127));
    fill = 1'($urandom_range(0, 1));
    for (int k = 0; k < 40; k++) begin
      f = 64'($urandom_range(2, 127));
      if (prod * f > TOP_VALUE) break;
      prod = prod * f;
      if (!fill && $urandom_range(0, 3) == 0) break;
    end
    return prod[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] narrow_n();
    int w;
    logic [VW-1:0] n;
    w = $urandom_range(1, 14);
    n = VW'($urandom) & ((VW'(1) << w) - VW'(1));
    if (n == '0) n = VW'(1);
    return n;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic send_n(input logic [VW-1:0] n);
    in_valid <= 1'b1;
    in_n_value <= n;
    do @(posedge clk); while (in_stall);
    phi_pending[exp_wr] = totient_of(n);
    exp_wr = exp_wr + 4'd1;
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // receiver: random stall bursts plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      sink_burst <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (sink_burst > 0) begin
      sink_burst <= sink_burst - 1;
      out_stall <= 1'b1;
    end else if (jitter_on && $urandom_range(0, 5) == 0) begin
      sink_burst <= $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [VW-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_wr == exp_rd) begin
        log_mismatch($sformatf("unexpected transaction, totient=%0d", out_totient));
      end else begin
        want = phi_pending[exp_rd];
        exp_rd <= exp_rd + 4'd1;
        if (out_totient !== want)
          log_mismatch($sformatf("totient mismatch: exp %0d, got %0d", want, out_totient));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // extremes, n = 0 and n = 1, prime powers, large primes, bit patterns
  task automatic test_edge_values();
    logic [VW-1:0] picks[NUM_EDGE];
    picks = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd9, 32'd36, 32'd97,
              32'd210, 32'd10201, 32'd65521, 32'd65536, 32'd65537, 32'd1000003,
              32'd1048573, 32'h8000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
              32'h5555_5555, 32'hFFFF_0000, 32'd3486784401};
    foreach (picks[i]) send_n(picks[i]);
  endtask

  task automatic test_random_narrow(input int count);
    repeat (count) send_n(narrow_n());
  endtask

  task automatic test_random_smooth(input int count);
    repeat (count) send_n(smooth_n());
  endtask

  // long receiver hold-off while the sender keeps offering short items
  task automatic test_backpressure();
    hold_req++;
    repeat (6) send_n(VW'($urandom_range(1, 255)));
  endtask

  task automatic test_quiet_stretch(input int count);
    repeat (count) begin
      if ($urandom_range(0, 1) == 0) send_n(narrow_n());
      else send_n(smooth_n());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_quiet_stretch(3);
    jitter_on = 1'b1;
    test_edge_values();
    test_random_narrow(25);
    test_random_smooth(30);
    test_backpressure();
    jitter_on = 1'b0;
    test_quiet_stretch(15);
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
